@@ sv/servo_pulse_sequencer_macros.svh @@
// Assertion macros shared by the servo pulse sequencer.
// Each macro checks a property on the rising clock edge and is switched off during reset.
`ifndef SERVO_PULSE_SEQUENCER_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define SPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/sps_pkg.sv @@
`timescale 1ns / 1ps

package sps_pkg;

  // Field widths of the item, result and configuration ports.
  localparam int PULSE_W  = 16;
  localparam int CH_W     = 4;
  localparam int CH_IDX_W = 5;
  localparam int OUT_PINS = 12;
  localparam int SERVO_W  = 4;
  localparam int CFG_W    = 16;

  // Minimum distance in ticks between the last pulse and the refresh restart.
  localparam int MARGIN_TICKS = 4;

  // Reset value of the refresh frame length.
  localparam logic [CFG_W-1:0] REFRESH_RESET = 16'd40000;

  // Item function codes.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SERVO_COUNT   = 1'b0;
  localparam logic REG_REFRESH_TICKS = 1'b1;

  // Channel index value that marks the refresh wait.
  localparam logic signed [CH_IDX_W-1:0] CH_IDLE = -5'sd1;

  // One entry of the channel table.
  typedef struct packed {
    logic [PULSE_W-1:0] pulse;
    logic               active;
  } sps_entry_t;

  // Write request into the channel table.
  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] channel;
    sps_entry_t      entry;
  } sps_wr_t;

endpackage

@@ sv/sps_ram.sv @@
`timescale 1ns / 1ps

module sps_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 12
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sps_table.sv @@
`timescale 1ns / 1ps

module sps_table #(
  parameter int CHANNELS = 12
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  sps_pkg::sps_wr_t                              wr,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  output sps_pkg::sps_entry_t                           rd_entry
);

  import sps_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = $bits(sps_entry_t);

  logic                wr_ok;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       ram_q;
  logic [CHANNELS-1:0] valid_r, valid_nxt;
  logic                hit_r, hit_nxt;
  logic                byp_r, byp_nxt;
  sps_entry_t          byp_entry_r;

  // Writes to channels beyond the table are dropped.
  assign wr_ok   = wr.en && ({1'b0, wr.channel} < (CH_W + 1)'(CHANNELS));
  assign wr_addr = wr.channel[AW-1:0];

  sps_ram #(
    .WIDTH(EW),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(wr_addr),
    .wdata(wr.entry),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Valid bits stand in for the all-zero reset of the table; a write that
  // lands on the address being read is forwarded past the memory.
  always_comb begin
    valid_nxt = valid_r;
    if (wr_ok) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    hit_nxt = valid_r[rd_addr];
    byp_nxt = wr_ok && (wr_addr == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byp_nxt) begin
      byp_entry_r <= wr.entry;
    end
  end

  // Read data of the entry addressed in the previous cycle.
  always_comb begin
    if (byp_r) begin
      rd_entry = byp_entry_r;
    end else if (hit_r) begin
      rd_entry = sps_entry_t'(ram_q);
    end else begin
      rd_entry = '0;
    end
  end

endmodule

@@ sv/servo_pulse_sequencer.sv @@
`timescale 1ns / 1ps
`include "servo_pulse_sequencer_macros.svh"

// Servo pulse sequencer: pulses up to CHANNELS servo pins one after another
// from a single free-running tick counter and one compare value.
// Input channel (in_*): each item is either one timer tick (func 0) or a write
// of one channel's pulse width and active mark (func 1).
// Result channel (out_*): every item yields exactly one result, the pin levels
// and the channel being pulsed (-1 during the refresh wait) after that item.
// Configuration (cfg_*): servo_count and refresh_ticks, written while idle.
// The result of an item is registered at the edge that accepts it. One item
// is taken every cycle unless a held result stalls the input; the channel table
// sits in a one-port-read memory read one channel ahead of the sequencer, so a
// compare match in any cycle finds the next channel's entry already there.
// Reset clears the counter and compare value, puts the sequencer in the
// refresh wait, clears all pins and the table, sets refresh_ticks to 40000.
// A stalled result holds; while it waits, no new item is accepted.
module servo_pulse_sequencer #(
  parameter int CHANNELS     = 12,
  parameter int COUNTER_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input item channel.
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_func,
  input  logic [sps_pkg::CH_W-1:0]                in_channel,
  input  logic [sps_pkg::PULSE_W-1:0]             in_pulse_ticks,
  input  logic                                    in_active,
  // Result item channel.
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [sps_pkg::OUT_PINS-1:0]            out_pin_levels,
  output logic signed [sps_pkg::CH_IDX_W-1:0]     out_current_channel,
  // Configuration write port.
  input  logic                                    cfg_we,
  input  logic                                    cfg_addr,
  input  logic [sps_pkg::CFG_W-1:0]               cfg_wdata
);

  import sps_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = ((COUNTER_BITS > PULSE_W) ? COUNTER_BITS : PULSE_W) + 1;
  localparam logic [CH_IDX_W-1:0] CH_LIM = CH_IDX_W'(CHANNELS);

  // Configuration registers.
  logic [SERVO_W-1:0]          servo_r;
  logic [CFG_W-1:0]            refresh_r;

  // Sequencer state.
  logic [COUNTER_BITS-1:0]     tick_r, tick_nxt;
  logic [COUNTER_BITS-1:0]     cmp_r, cmp_nxt;
  logic signed [CH_IDX_W-1:0]  ch_r, ch_nxt;
  logic [CHANNELS-1:0]         pin_r, pin_nxt;
  logic                        cur_act_r, cur_act_nxt;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_PINS-1:0]         out_pin_r;
  logic signed [CH_IDX_W-1:0]  out_ch_r;
  logic [OUT_PINS-1:0]         pin_view;

  // Handshake and decode.
  logic                        in_acc;
  logic                        is_tick;
  logic                        is_write;

  // Match step helpers.
  logic                        match;
  logic                        waiting;
  logic [CH_IDX_W-1:0]         ch_u;
  logic                        cur_use;
  logic [CH_IDX_W-1:0]         nc_u;
  logic                        nc_use;
  logic [COUNTER_BITS-1:0]     tick0;
  logic [SW-1:0]               pulse_ext;
  logic [COUNTER_BITS-1:0]     pulse_cb;
  logic [SW-1:0]               tick_m;
  logic [SW-1:0]               refresh_ext;

  // Table access.
  sps_wr_t                     tbl_wr;
  sps_entry_t                  nc_entry;
  logic [CH_IDX_W-1:0]         rd_next;
  logic [AW-1:0]               rd_addr;

  // A new item is taken unless a finished result is held by the receiver.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign is_tick  = in_acc & (in_func == FUNC_TICK);
  assign is_write = in_acc & (in_func == FUNC_WRITE);

  // Channel table write request.
  always_comb begin
    tbl_wr.en           = is_write;
    tbl_wr.channel      = in_channel;
    tbl_wr.entry.pulse  = in_pulse_ticks;
    tbl_wr.entry.active = in_active;
  end

  sps_table #(
    .CHANNELS(CHANNELS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_entry(nc_entry)
  );

  // Current and next channel, and whether each is in use.
  assign waiting = (ch_r == CH_IDLE);
  assign ch_u    = ch_r;
  assign cur_use = !waiting && (ch_u < CH_LIM) && (ch_u < {1'b0, servo_r});
  assign nc_u    = waiting ? '0 : ch_u + CH_IDX_W'(1);
  assign nc_use  = (nc_u < CH_LIM) && (nc_u < {1'b0, servo_r});
  assign match   = (tick_r == cmp_r);
  assign tick0   = waiting ? '0 : tick_r;

  // Compare candidates: end of the next pulse, or the refresh deadline.
  assign pulse_ext   = SW'(nc_entry.pulse);
  assign pulse_cb    = pulse_ext[COUNTER_BITS-1:0];
  assign tick_m      = SW'(tick0) + SW'(MARGIN_TICKS);
  assign refresh_ext = SW'(refresh_r);

  // Sequencer step for one item.
  always_comb begin
    tick_nxt    = tick_r;
    cmp_nxt     = cmp_r;
    ch_nxt      = ch_r;
    pin_nxt     = pin_r;
    cur_act_nxt = cur_act_r;
    if (is_write) begin
      // A write to the channel being pulsed changes how its pin is dropped.
      if (!waiting && (ch_u == {1'b0, in_channel})) begin
        cur_act_nxt = in_active;
      end
    end else if (is_tick) begin
      tick_nxt = tick_r + COUNTER_BITS'(1);
      if (match) begin
        if (cur_use && cur_act_r) begin
          pin_nxt[ch_u[AW-1:0]] = 1'b0;
        end
        if (nc_use) begin
          cmp_nxt     = tick0 + pulse_cb;
          ch_nxt      = nc_u;
          cur_act_nxt = nc_entry.active;
          if (nc_entry.active) begin
            pin_nxt[nc_u[AW-1:0]] = 1'b1;
          end
        end else begin
          if (tick_m < refresh_ext) begin
            cmp_nxt = refresh_ext[COUNTER_BITS-1:0];
          end else begin
            cmp_nxt = tick_m[COUNTER_BITS-1:0];
          end
          ch_nxt = CH_IDLE;
        end
        tick_nxt = tick0 + COUNTER_BITS'(1);
      end
    end
  end

  // Read the table one channel ahead of the state being written.
  always_comb begin
    rd_next = (ch_nxt == CH_IDLE) ? '0 : ch_nxt + CH_IDX_W'(1);
    if (rd_next < CH_LIM) begin
      rd_addr = rd_next[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Pins shown on the result port.
  for (genvar i = 0; i < OUT_PINS; i++) begin : g_view
    if (i < CHANNELS) begin : g_pin
      assign pin_view[i] = pin_nxt[i];
    end else begin : g_none
      assign pin_view[i] = 1'b0;
    end
  end

  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_r     <= '0;
      refresh_r   <= REFRESH_RESET;
      tick_r      <= '0;
      cmp_r       <= '0;
      ch_r        <= CH_IDLE;
      pin_r       <= '0;
      cur_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SERVO_COUNT:   servo_r   <= cfg_wdata[SERVO_W-1:0];
          REG_REFRESH_TICKS: refresh_r <= cfg_wdata;
          default:           servo_r   <= servo_r;
        endcase
      end
      tick_r      <= tick_nxt;
      cmp_r       <= cmp_nxt;
      ch_r        <= ch_nxt;
      pin_r       <= pin_nxt;
      cur_act_r   <= cur_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with the state after each accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pin_r <= pin_view;
      out_ch_r  <= ch_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pin_levels      = out_pin_r;
  assign out_current_channel = out_ch_r;

  // A match in the refresh wait restarts the frame with a cleared counter.
  `SPS_ASSERT_NEXT(a_restart_clears, clk, rst_n, is_tick && match && waiting,
    tick_r == COUNTER_BITS'(1), "refresh restart did not clear the counter")

  // Leaving the refresh wait goes to channel zero or straight back to waiting.
  `SPS_ASSERT_NEXT(a_restart_channel, clk, rst_n, is_tick && match && waiting,
    ch_r == '0 || ch_r == CH_IDLE, "refresh restart went to a wrong channel")

  // A taken result with no new item empties the result register.
  `SPS_ASSERT_NEXT(a_out_drain, clk, rst_n, out_valid_r && !out_stall && !in_acc,
    !out_valid_r, "result register did not drain")

  // Items are only refused while a result is held.
  `SPS_ASSERT_SAME(a_stall_cause, clk, rst_n, in_valid && !in_acc,
    out_valid_r, "input refused with an empty result register")

endmodule
